@@ rtl/b64d_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the base64 decoder
package b64d_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int FIFO_DEPTH_DEFAULT = 4;

   localparam logic [7:0] DIGIT_62_RESET = 8'd43;
   localparam logic [7:0] DIGIT_63_RESET = 8'd47;
   localparam logic [7:0] PAD_CHAR_RESET = 8'd61;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DIGIT_62 = 2'd0,
      CSR_DIGIT_63 = 2'd1,
      CSR_PAD_CHAR = 2'd2
   } csr_index_type;

   // one finished group: 24 accumulated bits and how many bytes to release (1..3)
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  n_bytes;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

@@ rtl/b64d_front.sv @@
`timescale 1ns / 1ps
// front end: character classification, group accumulation and configuration registers
module b64d_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // char_in
   input  logic                              req_tlast,   // end_of_input
   input  logic                              csr_we,
   input  logic [b64d_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [b64d_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  b64d_pkg::fifo_status_type         fifo_st,
   output logic                              push,
   output b64d_pkg::group_type               push_group
);
   import b64d_pkg::*;

   logic [7:0]        digit62_ff;
   logic [7:0]        digit63_ff;
   logic [7:0]        pad_ff;

   logic [23:0]       acc_ff, acc_in;
   logic [1:0]        digits_ff, digits_in;
   logic signed [2:0] bte_ff, bte_in;

   logic              accept;
   logic              is_pad;
   logic              is_alpha;
   logic [5:0]        alpha_val;
   logic [5:0]        digit_val;
   logic              counted;
   logic              group_done;
   logic signed [2:0] bte_dec;
   logic [23:0]       acc_shift;

   assign req_tready = !fifo_st.full;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit62_ff <= DIGIT_62_RESET;
         digit63_ff <= DIGIT_63_RESET;
         pad_ff     <= PAD_CHAR_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_DIGIT_62: digit62_ff <= csr_wdata;
            CSR_DIGIT_63: digit63_ff <= csr_wdata;
            CSR_PAD_CHAR: pad_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // fixed ranges win over the two symbol registers
   always_comb begin
      is_alpha  = 1'b1;
      alpha_val = 6'd0;
      priority if (req_tdata >= 8'd65 && req_tdata <= 8'd90) begin
         alpha_val = 6'(req_tdata - 8'd65);
      end else if (req_tdata >= 8'd97 && req_tdata <= 8'd122) begin
         alpha_val = 6'(req_tdata - 8'd71);
      end else if (req_tdata >= 8'd48 && req_tdata <= 8'd57) begin
         alpha_val = 6'(req_tdata + 8'd4);
      end else if (req_tdata == digit62_ff) begin
         alpha_val = 6'd62;
      end else if (req_tdata == digit63_ff) begin
         alpha_val = 6'd63;
      end else begin
         is_alpha = 1'b0;
      end
   end

   always_comb begin
      is_pad     = (req_tdata == pad_ff);
      digit_val  = is_pad ? 6'd0 : alpha_val;
      counted    = is_pad || is_alpha;
      bte_dec    = bte_ff - $signed({2'b00, is_pad});
      acc_shift  = {acc_ff[17:0], digit_val};
      group_done = counted && (digits_ff == 2'd3);

      push               = accept && group_done && (bte_dec > 3'sd0);
      push_group.bits    = acc_shift;
      push_group.n_bytes = bte_dec[1:0];

      acc_in    = acc_ff;
      digits_in = digits_ff;
      bte_in    = bte_ff;
      if (accept && counted) begin
         acc_in    = acc_shift;
         digits_in = digits_ff + 2'd1;
         bte_in    = bte_dec;
      end
      // group restarts after four characters, and end of stream drops a partial group
      if (accept && ((counted && group_done) || req_tlast)) begin
         acc_in    = 24'd0;
         digits_in = 2'd0;
         bte_in    = 3'sd3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= 24'd0;
         digits_ff <= 2'd0;
         bte_ff    <= 3'sd3;
      end else begin
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         bte_ff    <= bte_in;
      end
   end

endmodule

@@ rtl/b64d_fifo.sv @@
`timescale 1ns / 1ps
// short queue of finished groups between front and back end
module b64d_fifo #(
   parameter int DEPTH = b64d_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  b64d_pkg::group_type       push_group,
   input  logic                      pop,
   output b64d_pkg::group_type       pop_group,
   output b64d_pkg::fifo_status_type fifo_st
);
   import b64d_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   group_type        store_mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign fifo_st.full  = (count_ff == FULL_CNT);
   assign fifo_st.empty = (count_ff == '0);
   assign do_push       = push && !fifo_st.full;
   assign do_pop        = pop && !fifo_st.empty;
   assign pop_group     = store_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_mem[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/b64d_back.sv @@
`timescale 1ns / 1ps
// back end: unpacks queued groups into bytes behind an output register
module b64d_back (
   input  logic                      clock,
   input  logic                      reset,
   input  b64d_pkg::fifo_status_type fifo_st,
   input  b64d_pkg::group_type       pop_group,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // data_byte
   output logic                      rsp_tlast    // group_last
);
   import b64d_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic [15:0] rest_ff, rest_in;
   logic [1:0]  left_ff, left_in;
   logic        out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      rest_in      = rest_ff;
      left_in      = left_ff;
      pop          = 1'b0;
      if (out_free) begin
         priority if (left_ff != 2'd0) begin
            // remaining bytes of the current group, high byte first
            out_valid_in = 1'b1;
            out_byte_in  = rest_ff[15:8];
            out_last_in  = (left_ff == 2'd1);
            rest_in      = {rest_ff[7:0], 8'd0};
            left_in      = left_ff - 2'd1;
         end else if (!fifo_st.empty) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            out_byte_in  = pop_group.bits[23:16];
            out_last_in  = (pop_group.n_bytes == 2'd1);
            rest_in      = pop_group.bits[15:0];
            left_in      = pop_group.n_bytes - 2'd1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      rest_ff     <= rest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         left_ff      <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
      end
   end

endmodule

@@ rtl/base64_decoder_top.sv @@
`timescale 1ns / 1ps
// the request that completes a group writes it into the queue; its first byte then passes through the output register
// throughput: one character request per cycle; bytes leave at one per cycle while rsp_tready is high
// the front stalls only when the group queue of FIFO_DEPTH entries is full
// the bytes of a group pass through the output register one after another, high byte first
// reset (synchronous, active high) restores the symbol registers to + / =,
// drops the partial group and empties the queue
module base64_decoder_top #(
   parameter int FIFO_DEPTH = b64d_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // char_in
   input  logic                            req_tlast,   // end_of_input
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // data_byte
   output logic                            rsp_tlast,   // group_last
   input  logic                            csr_we,
   input  logic [b64d_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [b64d_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import b64d_pkg::*;

   fifo_status_type fifo_st;
   group_type       push_group;
   group_type       pop_group;
   logic            push;
   logic            pop;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fifo_st    (fifo_st),
      .push       (push),
      .push_group (push_group)
   );

   b64d_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .pop_group  (pop_group),
      .fifo_st    (fifo_st)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_st    (fifo_st),
      .pop_group  (pop_group),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(fifo_st.full && fifo_st.empty))
      else $error("group queue reports full and empty");

   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a decoded group");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      (!fifo_st.empty && rsp_tready) |=> rsp_tvalid)
      else $error("queued group not taken by the back end");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_st.full)
      else $error("group pushed into a full queue");
`endif

endmodule
